// ----- rtl/core/assert_macros.svh -----
// assertion helpers, included by the parser top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked in the following cycle
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/core/mtep_pkg.sv -----
package mtep_pkg;

    // parser phase
    typedef enum logic [3:0] {
        PH_DELTA  = 4'd0,
        PH_STATUS = 4'd1,
        PH_DATA1  = 4'd2,
        PH_DATA2  = 4'd3,
        PH_MTYPE  = 4'd4,
        PH_MLEN   = 4'd5,
        PH_XLEN   = 4'd6,
        PH_SKIP   = 4'd7,
        PH_IDLE   = 4'd8
    } phase_t;

    // func codes on the input side
    localparam logic [1:0] FUNC_PLAIN     = 2'd0;
    localparam logic [1:0] FUNC_NEW_TRACK = 2'd1;
    localparam logic [1:0] FUNC_NEW_FILE  = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_NOTE_OFF = 3'd0;
    localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
    localparam logic [2:0] KIND_CHANNEL  = 3'd2;
    localparam logic [2:0] KIND_TEMPO    = 3'd3;
    localparam logic [2:0] KIND_EOT      = 3'd4;
    localparam logic [2:0] KIND_MISSING  = 3'd5;

    // byte codes
    localparam logic [7:0] BYTE_META     = 8'hFF;
    localparam logic [7:0] BYTE_SYSEX    = 8'hF0;
    localparam logic [7:0] BYTE_SYSEX_ESC = 8'hF7;
    localparam logic [7:0] META_EOT      = 8'h2F;
    localparam logic [7:0] META_TEMPO    = 8'h51;
    localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
    localparam logic [3:0] HI_NOTE_ON    = 4'h9;
    localparam logic [3:0] HI_PROGRAM    = 4'hC;
    localparam logic [3:0] HI_PRESSURE   = 4'hD;
    localparam logic [3:0] HI_SYSTEM     = 4'hF;

    localparam int unsigned TEMPO_BYTES  = 3;

    // full parser state
    typedef struct packed {
        phase_t      phase;
        logic [7:0]  running_status;
        logic [7:0]  current_status;
        logic [31:0] delta_accum;
        logic [7:0]  first_byte_hold;
        logic [7:0]  meta_kind;
        logic [31:0] length_accum;
        logic [23:0] tempo_value;
        logic [1:0]  tempo_count;
        logic        tempo_captured;
    } state_t;

    // one result word
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  status_byte;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [31:0] delta_ticks;
        logic [23:0] tempo_us;
    } result_t;

endpackage

// ----- rtl/core/mtep_step.sv -----
module mtep_step (
    input  mtep_pkg::state_t  cur,
    input  logic [1:0]        func,
    input  logic [7:0]        data_byte,
    output mtep_pkg::state_t  nxt,
    output logic              emit,
    output mtep_pkg::result_t res
);
    import mtep_pkg::*;

    // statuses that take a single data byte
    function automatic logic one_data(input logic [7:0] st);
        return (st[7:4] == HI_PROGRAM) || (st[7:4] == HI_PRESSURE);
    endfunction

    // kind of a finished channel message
    function automatic logic [2:0] chan_kind(input logic [7:0] st, input logic [7:0] d2);
        logic [2:0] k;
        k = KIND_CHANNEL;
        if (st[7:4] == HI_NOTE_OFF)
            k = KIND_NOTE_OFF;
        else if (st[7:4] == HI_NOTE_ON)
            k = (d2 == 8'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
        return k;
    endfunction

    // one byte of parsing
    always_comb
    begin
        state_t      s;
        logic [31:0] len;
        logic [23:0] tv;
        logic [1:0]  tc;
        s   = cur;
        len = '0;
        tv  = '0;
        tc  = '0;
        emit = 1'b0;
        res  = '0;

        // track or file restart
        if (func == FUNC_NEW_TRACK || func == FUNC_NEW_FILE)
        begin
            s.phase           = PH_DELTA;
            s.running_status  = '0;
            s.current_status  = '0;
            s.delta_accum     = '0;
            s.first_byte_hold = '0;
            s.meta_kind       = '0;
            s.length_accum    = '0;
            if (func == FUNC_NEW_FILE)
            begin
                s.tempo_value    = '0;
                s.tempo_count    = '0;
                s.tempo_captured = 1'b0;
            end
        end

        unique case (s.phase)
            PH_DELTA:
            begin
                s.delta_accum = {s.delta_accum[24:0], data_byte[6:0]};
                if (!data_byte[7])
                    s.phase = PH_STATUS;
            end
            PH_STATUS:
            begin
                if (!data_byte[7])
                begin
                    if (s.running_status == 8'd0)
                    begin
                        emit            = 1'b1;
                        res.kind        = KIND_MISSING;
                        res.first_data  = data_byte;
                        res.delta_ticks = s.delta_accum;
                        s.delta_accum   = {24'd0, data_byte};
                    end
                    else
                    begin
                        s.current_status = s.running_status;
                        if (one_data(s.running_status))
                        begin
                            emit            = 1'b1;
                            res.kind        = chan_kind(s.running_status, 8'd0);
                            res.status_byte = s.running_status;
                            res.first_data  = data_byte;
                            res.delta_ticks = s.delta_accum;
                            s.phase         = PH_DELTA;
                            s.delta_accum   = '0;
                        end
                        else
                        begin
                            s.first_byte_hold = data_byte;
                            s.phase           = PH_DATA2;
                        end
                    end
                end
                else if (data_byte[7:4] == HI_SYSTEM)
                begin
                    s.running_status = '0;
                    if (data_byte == BYTE_META)
                        s.phase = PH_MTYPE;
                    else if (data_byte == BYTE_SYSEX || data_byte == BYTE_SYSEX_ESC)
                    begin
                        s.meta_kind    = '0;
                        s.length_accum = '0;
                        s.phase        = PH_XLEN;
                    end
                    else
                    begin
                        s.phase       = PH_DELTA;
                        s.delta_accum = '0;
                    end
                end
                else
                begin
                    s.running_status = data_byte;
                    s.current_status = data_byte;
                    s.phase          = PH_DATA1;
                end
            end
            PH_DATA1:
            begin
                if (one_data(s.current_status))
                begin
                    emit            = 1'b1;
                    res.kind        = chan_kind(s.current_status, 8'd0);
                    res.status_byte = s.current_status;
                    res.first_data  = data_byte;
                    res.delta_ticks = s.delta_accum;
                    s.phase         = PH_DELTA;
                    s.delta_accum   = '0;
                end
                else
                begin
                    s.first_byte_hold = data_byte;
                    s.phase           = PH_DATA2;
                end
            end
            PH_DATA2:
            begin
                emit            = 1'b1;
                res.kind        = chan_kind(s.current_status, data_byte);
                res.status_byte = s.current_status;
                res.first_data  = s.first_byte_hold;
                res.second_data = data_byte;
                res.delta_ticks = s.delta_accum;
                s.phase         = PH_DELTA;
                s.delta_accum   = '0;
            end
            PH_MTYPE:
            begin
                s.meta_kind    = data_byte;
                s.length_accum = '0;
                s.phase        = PH_MLEN;
            end
            PH_MLEN, PH_XLEN:
            begin
                len = {s.length_accum[24:0], data_byte[6:0]};
                s.length_accum = len;
                if (!data_byte[7])
                begin
                    if (s.phase == PH_MLEN && s.meta_kind == META_EOT)
                    begin
                        // end of track: report and go idle
                        emit            = 1'b1;
                        res.kind        = KIND_EOT;
                        res.status_byte = BYTE_META;
                        res.first_data  = META_EOT;
                        res.delta_ticks = s.delta_accum;
                        s.phase         = PH_IDLE;
                        s.delta_accum   = '0;
                    end
                    else
                    begin
                        if (s.phase == PH_XLEN)
                            s.meta_kind = '0;
                        if (!s.tempo_captured)
                            s.tempo_value = '0;
                        s.tempo_count = '0;
                        if (len == 32'd0)
                        begin
                            s.phase       = PH_DELTA;
                            s.delta_accum = '0;
                        end
                        else
                            s.phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP:
            begin
                // capture the first tempo of the file
                if (s.meta_kind == META_TEMPO && !s.tempo_captured
                    && s.tempo_count != 2'(TEMPO_BYTES))
                begin
                    tv = {s.tempo_value[15:0], data_byte};
                    tc = s.tempo_count + 2'd1;
                    s.tempo_value = tv;
                    s.tempo_count = tc;
                    if (tc == 2'(TEMPO_BYTES))
                    begin
                        s.tempo_captured = 1'b1;
                        emit             = 1'b1;
                        res.kind         = KIND_TEMPO;
                        res.status_byte  = BYTE_META;
                        res.first_data   = META_TEMPO;
                        res.delta_ticks  = s.delta_accum;
                        res.tempo_us     = tv;
                    end
                end
                len = s.length_accum - 32'd1;
                s.length_accum = len;
                if (len == 32'd0)
                begin
                    s.phase       = PH_DELTA;
                    s.delta_accum = '0;
                end
            end
            PH_IDLE:
            begin
                s.phase = PH_IDLE;
            end
            default:
            begin
                s.phase = PH_IDLE;
            end
        endcase

        nxt = s;
    end

endmodule

// ----- rtl/core/mtep_out_reg.sv -----
module mtep_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  mtep_pkg::result_t load_data,
    input  logic              take,
    output logic              valid,
    output mtep_pkg::result_t data
);
    import mtep_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // slot is full after a load, empty once the word is taken
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ----- rtl/core/midi_track_event_parser.sv -----
// channel   dir  tdata                       tuser
// s_axis    in   data_byte[7:0]              func[1:0]
// m_axis    out  status,first,second,delta,  kind[2:0]
//                tempo (80 bits)
//
// one byte per cycle while the result slot is free or being taken; a result
// word is registered with the full parse step between input and result register
// the parser state advances when the input register hands its byte to the
// result register, which needs the result slot empty or being taken
// a stalled result slot still lets one more byte sit in the input register
// rst_n clears phase, running status, delta, length and tempo capture state
module midi_track_event_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // status_byte, first_data, second_data,
                                   // delta_ticks[31:0], tempo_us[23:0]
    output logic [2:0]  m_tuser    // kind[2:0]
);
    import mtep_pkg::*;

    `include "assert_macros.svh"

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] byte_reg;
    logic [1:0] func_reg;
    state_t     state_reg;
    state_t     state_next;
    logic       emit;
    result_t    res;
    result_t    out_data;
    logic       advance;
    logic       s_accept;

    // handshake between the two stages
    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    // input register and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '{phase: PH_DELTA, default: '0};
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            byte_reg <= s_tdata;
            func_reg <= s_tuser;
        end
    end

    // parse step
    mtep_step u_step (
        .cur       (state_reg),
        .func      (func_reg),
        .data_byte (byte_reg),
        .nxt       (state_next),
        .emit      (emit),
        .res       (res)
    );

    // result register
    mtep_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && emit),
        .load_data (res),
        .take      (m_tready),
        .valid     (m_tvalid),
        .data      (out_data)
    );

    assign m_tuser = out_data.kind;
    assign m_tdata = {out_data.tempo_us, out_data.delta_ticks, out_data.second_data,
                      out_data.first_data, out_data.status_byte};

    // checks
    `ASSERT_NEXT(a_hold_in, in_valid_reg && !advance,
        in_valid_reg && $stable(byte_reg) && $stable(func_reg),
        "stalled input byte changed")
    `ASSERT_CLK(a_kind_range, emit |-> (res.kind <= KIND_MISSING),
        "result kind out of range")
    `ASSERT_CLK(a_idle_quiet,
        (state_reg.phase == PH_IDLE && func_reg != FUNC_NEW_TRACK
         && func_reg != FUNC_NEW_FILE) |-> !emit,
        "result produced while idle")
    `ASSERT_CLK(a_tempo_once,
        (state_reg.tempo_captured && func_reg != FUNC_NEW_FILE && emit)
        |-> (res.kind != KIND_TEMPO),
        "second tempo reported in one file")
    `ASSERT_NEXT(a_no_drop, m_tvalid && !m_tready, m_tvalid && $stable(out_data),
        "pending result lost")

endmodule

// ----- bench/midi_track_event_parser_checker.sv -----
module midi_track_event_parser_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic [1:0]  s_tuser,   // func[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,   // status_byte, first_data, second_data,
                                   // delta_ticks[31:0], tempo_us[23:0]
    input  logic [2:0]  m_tuser,   // kind[2:0]
    output int unsigned errors,
    output int unsigned pending,
    output int unsigned events_checked,
    output logic [5:0]  kinds_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import mtep_pkg::*;

    localparam int unsigned REPORT_LIMIT = 10;

    // shadow copy of the parser state
    phase_t      ph;
    logic [7:0]  run_st;
    logic [7:0]  cur_st;
    logic [7:0]  hold_b;
    logic [7:0]  meta_type;
    logic [31:0] delta;
    logic [31:0] skip_len;
    logic [23:0] tempo;
    logic [1:0]  tempo_n;
    logic        tempo_done;

    // events predicted but not yet seen on the output
    result_t pending_events[$];

    function automatic result_t make_event(logic [2:0] k, logic [7:0] st, logic [7:0] d1,
                                           logic [7:0] d2, logic [31:0] dt,
                                           logic [23:0] tp);
        result_t r;
        r.kind        = k;
        r.status_byte = st;
        r.first_data  = d1;
        r.second_data = d2;
        r.delta_ticks = dt;
        r.tempo_us    = tp;
        return r;
    endfunction

    // queue a predicted word at the tail
    function void add_expected(result_t r);
        pending_events.insert(pending_events.size(), r);
    endfunction

    function automatic logic takes_one_data(logic [7:0] st);
        return st[7:4] == HI_PROGRAM || st[7:4] == HI_PRESSURE;
    endfunction

    // a channel message is complete
    function void finish_channel(logic [7:0] d1, logic [7:0] d2);
        logic [2:0] k;
        k = KIND_CHANNEL;
        if (cur_st[7:4] == HI_NOTE_OFF)
            k = KIND_NOTE_OFF;
        else if (cur_st[7:4] == HI_NOTE_ON)
            k = (d2 == 8'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
        add_expected(make_event(k, cur_st, d1, d2, delta, 24'd0));
        ph    = PH_DELTA;
        delta = '0;
    endfunction

    // one parse step for an accepted byte
    function void parse_track_byte(logic [1:0] func, logic [7:0] b);
        if (func == FUNC_NEW_TRACK || func == FUNC_NEW_FILE)
        begin
            ph        = PH_DELTA;
            run_st    = '0;
            cur_st    = '0;
            delta     = '0;
            hold_b    = '0;
            meta_type = '0;
            skip_len  = '0;
            if (func == FUNC_NEW_FILE)
            begin
                tempo      = '0;
                tempo_n    = '0;
                tempo_done = 1'b0;
            end
        end

        case (ph)
            PH_DELTA:
            begin
                delta = {delta[24:0], b[6:0]};
                if (!b[7])
                    ph = PH_STATUS;
            end
            PH_STATUS:
            begin
                if (!b[7])
                begin
                    if (run_st == 8'd0)
                    begin
                        // data byte without status: the byte restarts the delta
                        add_expected(make_event(KIND_MISSING, 8'd0, b, 8'd0,
                                                delta, 24'd0));
                        delta = {24'd0, b};
                    end
                    else
                    begin
                        cur_st = run_st;
                        if (takes_one_data(cur_st))
                            finish_channel(b, 8'd0);
                        else
                        begin
                            hold_b = b;
                            ph     = PH_DATA2;
                        end
                    end
                end
                else if (b[7:4] == HI_SYSTEM)
                begin
                    run_st = '0;
                    if (b == BYTE_META)
                        ph = PH_MTYPE;
                    else if (b == BYTE_SYSEX || b == BYTE_SYSEX_ESC)
                    begin
                        meta_type = '0;
                        skip_len  = '0;
                        ph        = PH_XLEN;
                    end
                    else
                    begin
                        ph    = PH_DELTA;
                        delta = '0;
                    end
                end
                else
                begin
                    run_st = b;
                    cur_st = b;
                    ph     = PH_DATA1;
                end
            end
            PH_DATA1:
            begin
                if (takes_one_data(cur_st))
                    finish_channel(b, 8'd0);
                else
                begin
                    hold_b = b;
                    ph     = PH_DATA2;
                end
            end
            PH_DATA2:
                finish_channel(hold_b, b);
            PH_MTYPE:
            begin
                meta_type = b;
                skip_len  = '0;
                ph        = PH_MLEN;
            end
            PH_MLEN, PH_XLEN:
            begin
                skip_len = {skip_len[24:0], b[6:0]};
                if (!b[7])
                begin
                    if (ph == PH_MLEN && meta_type == META_EOT)
                    begin
                        // end of track reported at once, whatever its length
                        add_expected(make_event(KIND_EOT, BYTE_META, META_EOT,
                                                8'd0, delta, 24'd0));
                        ph    = PH_IDLE;
                        delta = '0;
                    end
                    else
                    begin
                        if (ph == PH_XLEN)
                            meta_type = '0;
                        if (!tempo_done)
                            tempo = '0;
                        tempo_n = '0;
                        if (skip_len == 32'd0)
                        begin
                            ph    = PH_DELTA;
                            delta = '0;
                        end
                        else
                            ph = PH_SKIP;
                    end
                end
            end
            PH_SKIP:
            begin
                // only the first set-tempo of a file is captured
                if (meta_type == META_TEMPO && !tempo_done && tempo_n < TEMPO_BYTES)
                begin
                    tempo   = {tempo[15:0], b};
                    tempo_n = tempo_n + 2'd1;
                    if (tempo_n == TEMPO_BYTES)
                    begin
                        tempo_done = 1'b1;
                        add_expected(make_event(KIND_TEMPO, BYTE_META, META_TEMPO,
                                                8'd0, delta, tempo));
                    end
                end
                skip_len = skip_len - 32'd1;
                if (skip_len == 32'd0)
                begin
                    ph    = PH_DELTA;
                    delta = '0;
                end
            end
            default:
                ph = PH_IDLE;
        endcase
    endfunction

    function void log_failure(string msg);
        errors = errors + 1;
        if (errors <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // predict on input words, compare on output words
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            ph         = PH_DELTA;
            run_st     = '0;
            cur_st     = '0;
            hold_b     = '0;
            meta_type  = '0;
            delta      = '0;
            skip_len   = '0;
            tempo      = '0;
            tempo_n    = '0;
            tempo_done = 1'b0;
            pending_events.delete();
            errors         = 0;
            pending        = 0;
            events_checked = 0;
            kinds_seen     = '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                parse_track_byte(s_tuser, s_tdata);

            if (m_tvalid && m_tready)
            begin
                got = make_event(m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[23:16],
                                 m_tdata[55:24], m_tdata[79:56]);
                if (got.kind < 3'd6)
                    kinds_seen[got.kind] = 1'b1;
                if (pending_events.size() == 0)
                    log_failure($sformatf("unexpected word kind=%0d st=%h d1=%h d2=%h dt=%h tp=%h",
                                          got.kind, got.status_byte, got.first_data,
                                          got.second_data, got.delta_ticks, got.tempo_us));
                else
                begin
                    want = pending_events.pop_front();
                    events_checked = events_checked + 1;
                    if (got !== want)
                        log_failure($sformatf({"expected kind=%0d st=%h d1=%h d2=%h dt=%h tp=%h",
                                               " got kind=%0d st=%h d1=%h d2=%h dt=%h tp=%h"},
                                              want.kind, want.status_byte, want.first_data,
                                              want.second_data, want.delta_ticks,
                                              want.tempo_us, got.kind, got.status_byte,
                                              got.first_data, got.second_data,
                                              got.delta_ticks, got.tempo_us));
                end
            end
            pending = pending_events.size();
        end
    end

endmodule

// ----- bench/midi_track_event_parser_tb.sv -----
module midi_track_event_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mtep_pkg::*;

    localparam logic [1:0]  FUNC_SPARE     = 2'd3;
    localparam logic [7:0]  VLQ_MORE       = 8'h80;
    localparam logic [7:0]  CH_STATUS_LO   = 8'h80;
    localparam logic [7:0]  CH_STATUS_HI   = 8'hEF;
    localparam logic [7:0]  SYS_UNKNOWN_LO = 8'hF1;
    localparam logic [7:0]  SYS_UNKNOWN_HI = 8'hFE;
    localparam int unsigned TARGET_BYTES   = 1350;
    localparam int unsigned HOLD_START     = 800;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned STALL_LIMIT    = 2000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned SPARE_AT       = 24;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] b;
    } track_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;   // data_byte[7:0]
    logic [1:0]  s_tuser = 2'd0;   // func[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;          // status_byte, first_data, second_data,
                                   // delta_ticks[31:0], tempo_us[23:0]
    logic [2:0]  m_tuser;          // kind[2:0]

    int unsigned errors;
    int unsigned pending;
    int unsigned events_checked;
    logic [5:0]  kinds_seen;

    track_word_t track_bytes[$];
    logic [1:0]  start_func;
    logic [7:0]  gen_rs;
    bit          delta_done;
    bit          random_part;

    always #2 clk = ~clk;

    midi_track_event_parser uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    midi_track_event_parser_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .errors         (errors),
        .pending        (pending),
        .events_checked (events_checked),
        .kinds_seen     (kinds_seen)
    );

    // append one byte, the pending func marker goes on it
    function void put_byte(logic [7:0] b);
        track_word_t w;
        w.func = start_func;
        w.b    = b;
        if (w.func == FUNC_PLAIN && random_part && $urandom_range(0, 29) == 0)
            w.func = FUNC_SPARE;
        start_func = FUNC_PLAIN;
        track_bytes.insert(track_bytes.size(), w);
    endfunction

    function logic [7:0] rand_data();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 127));
    endfunction

    // delta time with one to five groups, long ones overflow 32 bits
    function void put_delta();
        int n;
        if (delta_done)
        begin
            delta_done = 1'b0;
            return;
        end
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: n = 1;
            12, 13, 14, 15, 16: n = 2;
            17, 18: n = $urandom_range(3, 4);
            default: n = 5;
        endcase
        for (int i = 0; i < n - 1; i++)
            put_byte(VLQ_MORE | 8'($urandom_range(0, 127)));
        put_byte(8'($urandom_range(0, 127)));
    endfunction

    // small payload length, sometimes padded or with bits above 32
    function void put_length(logic [7:0] len);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 9)
        begin
            put_byte(VLQ_MORE | 8'($urandom_range(0, 7) << 4));
            repeat (3) put_byte(VLQ_MORE);
        end
        else if (pick >= 7)
            repeat ($urandom_range(1, 3)) put_byte(VLQ_MORE);
        put_byte(len);
    endfunction

    function void put_channel();
        logic [7:0] st;
        logic [7:0] d2;
        put_delta();
        if (gen_rs != 8'd0 && $urandom_range(0, 9) < 4)
        begin
            // running status: first data byte must look like data
            st = gen_rs;
            put_byte(8'($urandom_range(0, 127)));
        end
        else
        begin
            st     = 8'($urandom_range(CH_STATUS_LO, CH_STATUS_HI));
            gen_rs = st;
            put_byte(st);
            put_byte(rand_data());
        end
        if (st[7:4] != HI_PROGRAM && st[7:4] != HI_PRESSURE)
        begin
            d2 = rand_data();
            if (st[7:4] == HI_NOTE_ON && $urandom_range(0, 4) == 0)
                d2 = 8'd0;
            put_byte(d2);
        end
    endfunction

    function void put_payload_event(logic [7:0] lead, bit with_type, logic [7:0] mtype,
                                    logic [7:0] len);
        put_delta();
        put_byte(lead);
        if (with_type)
            put_byte(mtype);
        put_length(len);
        for (int i = 0; i < len; i++)
            put_byte(8'($urandom_range(0, 255)));
        gen_rs = 8'd0;
    endfunction

    function void put_random_event();
        logic [7:0] mtype;
        logic [7:0] b;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            put_channel();
        else if (pick < 74)
        begin
            if ($urandom_range(0, 9) < 4)
            begin
                case ($urandom_range(0, 7))
                    0: b = 8'd0;
                    1: b = 8'd1;
                    2: b = 8'd2;
                    3: b = 8'd4;
                    default: b = 8'd3;
                endcase
                put_payload_event(BYTE_META, 1'b1, META_TEMPO, b);
            end
            else
            begin
                do
                    mtype = 8'($urandom_range(0, 255));
                while (mtype == META_EOT);
                put_payload_event(BYTE_META, 1'b1, mtype, 8'($urandom_range(0, 6)));
            end
        end
        else if (pick < 82)
            put_payload_event($urandom_range(0, 1) ? BYTE_SYSEX : BYTE_SYSEX_ESC, 1'b0,
                              8'd0, 8'($urandom_range(0, 6)));
        else if (pick < 87)
        begin
            put_delta();
            do
                b = 8'($urandom_range(SYS_UNKNOWN_LO, SYS_UNKNOWN_HI));
            while (b == BYTE_SYSEX_ESC);
            put_byte(b);
            gen_rs = 8'd0;
        end
        else if (pick < 93 && gen_rs == 8'd0)
        begin
            // data byte with no status, it then serves as the next delta
            put_delta();
            put_byte(8'($urandom_range(0, 127)));
            delta_done = 1'b1;
        end
        else if (pick >= 97)
        begin
            repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
            delta_done = 1'b0;
        end
        else
            put_channel();
    endfunction

    function void build_stimulus();
        logic [7:0] opening [0:29];
        int n_events;
        opening = '{8'h00, 8'h90, 8'h3C, 8'h64,                // note on
                    8'h00, 8'h3C, 8'h00,                       // running status, velocity zero
                    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F,         // delta past 32 bits
                    8'hC5, 8'hFF,                              // program, data with top bit
                    8'h00, 8'hFF, 8'h51, 8'h03,                // set tempo
                    8'h07, 8'hA1, 8'h20,
                    8'h00, 8'h40,                              // missing status
                    8'hE0, 8'h00, 8'h7F,                       // pitch bend, spare func inside
                    8'h00, 8'hFF, 8'h2F, 8'h00};               // end of track
        random_part = 1'b0;
        start_func  = FUNC_NEW_FILE;
        foreach (opening[i])
        begin
            if (i == SPARE_AT)
                start_func = FUNC_SPARE;
            put_byte(opening[i]);
        end

        // random tracks, most of them well formed
        random_part = 1'b1;
        while (track_bytes.size() < TARGET_BYTES)
        begin
            start_func = ($urandom_range(0, 5) == 0) ? FUNC_NEW_FILE : FUNC_NEW_TRACK;
            gen_rs     = 8'd0;
            delta_done = 1'b0;
            n_events   = $urandom_range(3, 30);
            for (int e = 0; e < n_events; e++)
                put_random_event();
            if ($urandom_range(0, 19) != 0)
            begin
                if ($urandom_range(0, 4) == 0)
                    put_payload_event(BYTE_META, 1'b1, META_EOT, 8'($urandom_range(1, 3)));
                else
                    put_payload_event(BYTE_META, 1'b1, META_EOT, 8'd0);
                // bytes after end of track are dropped by the parser
                repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    // hold one word until it is taken
    task automatic send_word(track_word_t w);
        s_tvalid <= 1'b1;
        s_tdata  <= w.b;
        s_tuser  <= w.func;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // receiver: changing stall patterns plus one long hold-off
    int unsigned rx_cycle = 0;
    int unsigned hold_left = 0;
    int unsigned mode_left = 0;
    int unsigned rx_mode = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rx_cycle = rx_cycle + 1;
            if (rx_cycle == HOLD_START)
                hold_left = HOLD_CYCLES;
            if (mode_left == 0)
            begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            else
                mode_left = mode_left - 1;
            if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end
            else
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= (rx_cycle % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 9) != 0);
                endcase
        end
    end

    // watchdog on cycles without any accepted word
    int unsigned quiet_cycles = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no word accepted for %0d cycles, %0d events pending",
                         quiet_cycles, pending);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // sender in bursts, then drain and verdict
    initial
    begin : stimulus
        int idx;
        int burst;
        int gap;
        build_stimulus();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        idx = 0;
        while (idx < track_bytes.size())
        begin
            burst = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
            for (int k = 0; k < burst && idx < track_bytes.size(); k++)
            begin
                send_word(track_bytes[idx]);
                idx++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("run covered %0d input bytes over new files, tracks, meta, sysex and noise",
                 track_bytes.size());
        $display("%0d events checked, result kinds seen (kind 5 down to 0): %b",
                 events_checked, kinds_seen);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/mtep_pkg.sv
rtl/core/mtep_step.sv
rtl/core/mtep_out_reg.sv
rtl/core/midi_track_event_parser.sv
bench/midi_track_event_parser_checker.sv
bench/midi_track_event_parser_tb.sv
